[rtl/core/lds_pkg.sv]
package lds_pkg;

  localparam int MAX_CHARS         = 6;
  localparam int SEGMENTS          = 22;
  localparam int ANODE_TOP_PORT    = 31;
  localparam int SEGMENT_BASE_PORT = 4;
  localparam int PORT_REG_BASE     = 32;

  localparam int IDX_W  = 3;
  localparam int SEG_W  = 22;
  localparam int ADDR_W = 7;
  localparam int CNT_W  = 5;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 8;

  localparam logic [ADDR_W-1:0] ANODE_ADDR_TOP = ADDR_W'(PORT_REG_BASE + ANODE_TOP_PORT);
  localparam logic [ADDR_W-1:0] SEG_ADDR_BASE  = ADDR_W'(PORT_REG_BASE + SEGMENT_BASE_PORT);

  localparam logic [1:0] PH_OFF = 2'd0;
  localparam logic [1:0] PH_SEG = 2'd1;
  localparam logic [1:0] PH_ON  = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic       buf_we;
    logic       clr_cnt;
    logic       inc_cnt;
    logic       load;
    logic [1:0] phase;
    logic       last;
    logic       adv_pos;
  } lds_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_last;
  } lds_sts_t;

endpackage

[rtl/core/lds_ctrl.sv]
module lds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tuser,
  output logic              in_tready,
  input  lds_pkg::lds_sts_t sts,
  output lds_pkg::lds_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OFF  = 2'd1;
  localparam logic [1:0] ST_SEG  = 2'd2;
  localparam logic [1:0] ST_ON   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.phase   = lds_pkg::PH_OFF;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == lds_pkg::REQ_WRITE) begin
            cmd.buf_we = 1'b1;
          end else begin
            cmd.clr_cnt = 1'b1;
            state_nxt   = ST_OFF;
          end
        end
      end
      ST_OFF: begin
        cmd.phase = lds_pkg::PH_OFF;
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.cnt_last) begin
            cmd.clr_cnt = 1'b1;
            state_nxt   = ST_SEG;
          end else begin
            cmd.inc_cnt = 1'b1;
          end
        end
      end
      ST_SEG: begin
        cmd.phase = lds_pkg::PH_SEG;
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.cnt_last) begin
            cmd.clr_cnt = 1'b1;
            state_nxt   = ST_ON;
          end else begin
            cmd.inc_cnt = 1'b1;
          end
        end
      end
      ST_ON: begin
        cmd.phase = lds_pkg::PH_ON;
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.cnt_last) begin
            cmd.last    = 1'b1;
            cmd.adv_pos = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            cmd.inc_cnt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/lds_dpath.sv]
module lds_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lds_pkg::IDX_W-1:0]   cfg_wdata,
  input  logic [lds_pkg::IN_W-1:0]    in_tdata,
  input  lds_pkg::lds_cmd_t           cmd,
  output lds_pkg::lds_sts_t           sts,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lds_pkg::OUT_W-1:0]   out_tdata,
  output logic                        out_tlast
);

  logic [lds_pkg::IDX_W-1:0]  char_count_r;
  logic [lds_pkg::SEG_W-1:0]  buf_r [lds_pkg::MAX_CHARS];
  logic [lds_pkg::IDX_W-1:0]  pos_r;
  logic [lds_pkg::IDX_W-1:0]  pos_nxt;
  logic [lds_pkg::CNT_W-1:0]  cnt_r;
  logic                       out_valid_r;
  logic [lds_pkg::OUT_W-1:0]  out_data_r;
  logic                       out_last_r;

  logic [lds_pkg::IDX_W-1:0]  eff_count;
  logic [lds_pkg::IDX_W-1:0]  wr_idx;
  logic [lds_pkg::SEG_W-1:0]  wr_bits;
  logic [lds_pkg::SEG_W-1:0]  cur_word;
  logic [lds_pkg::ADDR_W-1:0] beat_addr;
  logic                       beat_value;
  logic [lds_pkg::CNT_W-1:0]  cnt_limit;

  assign wr_idx  = in_tdata[lds_pkg::IDX_W-1:0];
  assign wr_bits = in_tdata[lds_pkg::IDX_W +: lds_pkg::SEG_W];

  always_comb begin
    if (char_count_r == '0) begin
      eff_count = lds_pkg::IDX_W'(1);
    end else if (char_count_r > lds_pkg::IDX_W'(lds_pkg::MAX_CHARS)) begin
      eff_count = lds_pkg::IDX_W'(lds_pkg::MAX_CHARS);
    end else begin
      eff_count = char_count_r;
    end
  end

  always_comb begin
    if (pos_r < lds_pkg::IDX_W'(lds_pkg::MAX_CHARS)) begin
      cur_word = buf_r[pos_r];
    end else begin
      cur_word = buf_r[0];
    end
  end

  always_comb begin
    if (cmd.phase == lds_pkg::PH_SEG) begin
      cnt_limit = lds_pkg::CNT_W'(lds_pkg::SEGMENTS - 1);
    end else begin
      cnt_limit = lds_pkg::CNT_W'(eff_count) - lds_pkg::CNT_W'(1);
    end
  end

  assign sts.cnt_last = (cnt_r == cnt_limit);
  assign sts.out_free = !out_valid_r || out_tready;

  always_comb begin
    case (cmd.phase)
      lds_pkg::PH_SEG: begin
        beat_addr  = lds_pkg::SEG_ADDR_BASE + lds_pkg::ADDR_W'(cnt_r);
        beat_value = cur_word[cnt_r];
      end
      lds_pkg::PH_ON: begin
        beat_addr  = lds_pkg::ANODE_ADDR_TOP - lds_pkg::ADDR_W'(cnt_r);
        beat_value = (cnt_r != lds_pkg::CNT_W'(pos_r));
      end
      default: begin
        beat_addr  = lds_pkg::ANODE_ADDR_TOP - lds_pkg::ADDR_W'(cnt_r);
        beat_value = 1'b1;
      end
    endcase
  end

  always_comb begin
    pos_nxt = pos_r + lds_pkg::IDX_W'(1);
    if (pos_nxt >= eff_count) begin
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r <= lds_pkg::IDX_W'(lds_pkg::MAX_CHARS);
      pos_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < lds_pkg::MAX_CHARS; i++) begin
        buf_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        char_count_r <= cfg_wdata;
      end
      if (cmd.buf_we && (wr_idx < lds_pkg::IDX_W'(lds_pkg::MAX_CHARS))) begin
        buf_r[wr_idx] <= wr_bits;
      end
      if (cmd.adv_pos) begin
        pos_r <= pos_nxt;
      end
      if (cmd.clr_cnt) begin
        cnt_r <= '0;
      end else if (cmd.inc_cnt) begin
        cnt_r <= cnt_r + lds_pkg::CNT_W'(1);
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= {beat_value, beat_addr};
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < lds_pkg::CNT_W'(lds_pkg::SEGMENTS))
    else $error("beat counter beyond the segment count");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < lds_pkg::IDX_W'(lds_pkg::MAX_CHARS))
    else $error("scan position beyond the character count");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> sts.out_free)
    else $error("output register loaded while a beat is still held");

  a_last_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last |-> (cmd.adv_pos && cmd.phase == lds_pkg::PH_ON))
    else $error("final beat without a scan advance");

endmodule

[rtl/core/led_display_mux_scanner.sv]
// A buffer-write beat stores one character's segment word and gives no output.
// A tick beat produces SEGMENTS + 2 * count register-write beats (34 at the most),
// one per cycle while the output side takes them, and holds the input off until
// the last of them is loaded. The rate is set by the one output register, which the
// scan sequencer fills in each cycle that it is free. The next beat can be accepted
// as soon as the final write of a run is loaded.
module led_display_mux_scanner (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [lds_pkg::IDX_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // char_index[2:0], segment_bits[24:3], zero[31:25]
  input  logic [lds_pkg::IN_W-1:0]  in_tdata,
  // req_type
  input  logic                      in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // port_reg_addr[6:0], port_value[7]
  output logic [lds_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tlast
);

  lds_pkg::lds_cmd_t cmd;
  lds_pkg::lds_sts_t sts;

  lds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lds_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
